FILE: rtl/tlps_pkg.sv
// Shared types, register codes and defaults for the traffic light phase sequencer.
package tlps_pkg;

  localparam int MAX_PHASES_DEF     = 4;
  localparam int NUM_APPROACHES_DEF = 8;
  localparam int TIME_WIDTH_DEF     = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int COUNT_W     = 3;
  localparam int MS_W        = 16;
  localparam int TABLE_W     = 64;
  localparam int NUM_DUR     = 4;

  localparam logic [1:0] SIG_STOP   = 2'd0;
  localparam logic [1:0] SIG_GO     = 2'd1;
  localparam logic [1:0] SIG_YELLOW = 2'd2;
  localparam logic [1:0] SIG_STOP3  = 2'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_COUNT = 3'd0,
    REG_YELLOW      = 3'd1,
    REG_RED_DELAY   = 3'd2,
    REG_DUR0        = 3'd3,
    REG_DUR1        = 3'd4,
    REG_DUR2        = 3'd5,
    REG_DUR3        = 3'd6,
    REG_SIG_TABLE   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [COUNT_W-1:0]           phase_count;
    logic [MS_W-1:0]              yellow_time;
    logic [MS_W-1:0]              red_delay_time;
    logic [NUM_DUR-1:0][MS_W-1:0] phase_duration;
    logic [TABLE_W-1:0]           signal_table;
  } cfg_t;

  localparam logic [COUNT_W-1:0] RST_PHASE_COUNT = 3'd0;
  localparam logic [MS_W-1:0]    RST_YELLOW      = 16'd2000;
  localparam logic [MS_W-1:0]    RST_RED_DELAY   = 16'd1000;
  localparam logic [MS_W-1:0]    RST_DURATION    = 16'd6000;
  localparam logic [TABLE_W-1:0] RST_SIG_TABLE   = 64'd0;

  // Code of one approach in one phase; positions past the table read as stop.
  function automatic logic [1:0] table_signal(logic [TABLE_W-1:0] tbl, int phase,
                                              int approach, int num_approaches);
    int         pos;
    logic [1:0] code;
    pos = phase * 2 * num_approaches + approach * 2;
    if (pos >= TABLE_W) begin
      code = SIG_STOP;
    end else begin
      code = tbl[pos[5:0] +: 2];
      if (code == SIG_STOP3) code = SIG_STOP;
    end
    return code;
  endfunction

endpackage

FILE: rtl/traffic_light_phase_sequencer.sv
// Top level of the fixed-time traffic light phase sequencer.
// Takes one tick word per clock cycle unless the output stalls: the phase timer, phase change
// logic and signal decode are combinational between the tick input and the result register,
// so each result appears in the cycle after its tick is accepted. The result register is the
// only buffer; in_ready_o is high whenever it is empty or being emptied in the same cycle.
// Configuration writes take effect at once; the user must make them while no result is
// pending, as the block itself does not enforce it.
module traffic_light_phase_sequencer #(
  parameter int MAX_PHASES     = tlps_pkg::MAX_PHASES_DEF,
  parameter int NUM_APPROACHES = tlps_pkg::NUM_APPROACHES_DEF,
  parameter int TIME_WIDTH     = tlps_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlps_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tlps_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tlps_pkg::MS_W-1:0]        elapsed_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2*NUM_APPROACHES-1:0]      approach_signals_o,
  output logic [1:0]                       shown_phase_o,
  output logic [1:0]                       target_phase_o,
  output logic                             changing_o,
  output logic                             running_o
);
  import tlps_pkg::*;

  localparam int PHASE_W   = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int SUM_W     = ((TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W) + 1;
  localparam int CMP_W     = (TIME_WIDTH > MS_W + 1) ? TIME_WIDTH : MS_W + 1;
  localparam int MOD_STEPS = 3;  // (target+1)/count is at most 3 for 3-bit counts
  localparam logic [TIME_WIDTH-1:0] TIMER_MAX = '1;

  // (v) mod count for v up to 7 and count of at least 2
  function automatic logic [COUNT_W:0] small_mod(logic [COUNT_W:0] v, logic [COUNT_W-1:0] c);
    logic [COUNT_W:0] r;
    r = v;
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (r >= {1'b0, c}) r = r - {1'b0, c};
    end
    return r;
  endfunction

  cfg_t cfg;

  logic                  started_q, started_d;
  logic                  in_change_q, in_change_d;
  logic [PHASE_W-1:0]    shown_q, shown_d;
  logic [PHASE_W-1:0]    target_q, target_d;
  logic [TIME_WIDTH-1:0] timer_q, timer_d;

  logic                  out_valid_q;
  logic [2*NUM_APPROACHES-1:0] signals_q;
  logic [1:0]            shown_out_q, target_out_q;
  logic                  changing_q, running_q;

  logic [COUNT_W-1:0]    count_c;
  logic                  active;
  logic [TIME_WIDTH-1:0] base_timer, timer_sat;
  logic [SUM_W-1:0]      timer_sum;
  logic                  chg0;
  logic [PHASE_W-1:0]    shown0, target0, next_phase;
  logic [1:0]            dur_idx;
  logic                  in_yellow;
  logic                  in_fire;
  logic [2*NUM_APPROACHES-1:0] signals_d;

  tlps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    count_c    = (int'(cfg.phase_count) > MAX_PHASES) ? COUNT_W'(MAX_PHASES) : cfg.phase_count;
    active     = (count_c != '0);
    base_timer = started_q ? timer_q : '0;
    timer_sum  = SUM_W'(base_timer) + SUM_W'(elapsed_i);
    timer_sat  = (timer_sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX : timer_sum[TIME_WIDTH-1:0];
    // the first tick opens a change into phase 0
    shown0     = started_q ? shown_q : '0;
    target0    = started_q ? target_q : '0;
    chg0       = started_q ? in_change_q : 1'b1;
    dur_idx    = (shown0 > PHASE_W'(NUM_DUR - 1)) ? 2'(NUM_DUR - 1) : 2'(shown0);
    next_phase = PHASE_W'(small_mod(COUNT_W'(target0) + (COUNT_W+1)'(1), count_c));

    started_d   = started_q;
    in_change_d = in_change_q;
    shown_d     = shown_q;
    target_d    = target_q;
    timer_d     = timer_q;
    if (active) begin
      started_d   = 1'b1;
      shown_d     = shown0;
      target_d    = target0;
      in_change_d = chg0;
      timer_d     = timer_sat;
      if (chg0) begin
        if (CMP_W'(timer_sat) >= CMP_W'(cfg.yellow_time) + CMP_W'(cfg.red_delay_time)) begin
          shown_d     = target0;
          in_change_d = 1'b0;
        end
      end else if (CMP_W'(timer_sat) >= CMP_W'(cfg.phase_duration[dur_idx])) begin
        if (count_c > COUNT_W'(1)) begin
          target_d    = next_phase;
          in_change_d = 1'b1;
          timer_d     = '0;
        end
      end
    end
    in_yellow = CMP_W'(timer_d) < CMP_W'(cfg.yellow_time);
  end

  tlps_signal_map #(
    .NUM_APPROACHES(NUM_APPROACHES),
    .PHASE_W       (PHASE_W)
  ) u_map (
    .signal_table_i(cfg.signal_table),
    .shown_phase_i (shown_d),
    .target_phase_i(target_d),
    .in_change_i   (in_change_d),
    .in_yellow_i   (in_yellow),
    .all_go_i      (!started_d || !active),
    .signals_o     (signals_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      in_change_q <= 1'b0;
      shown_q     <= '0;
      target_q    <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        started_q   <= started_d;
        in_change_q <= in_change_d;
        shown_q     <= shown_d;
        target_q    <= target_d;
        timer_q     <= timer_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      signals_q    <= signals_d;
      shown_out_q  <= 2'(shown_d);
      target_out_q <= 2'(target_d);
      changing_q   <= in_change_d;
      running_q    <= started_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign approach_signals_o = signals_q;
  assign shown_phase_o      = shown_out_q;
  assign target_phase_o     = target_out_q;
  assign changing_o         = changing_q;
  assign running_o          = running_q;

  // outside a change the shown phase has caught up with the target
  a_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q && !in_change_q |-> shown_q == target_q)
    else $error("shown phase differs from target outside a change");

  a_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> !in_change_q && shown_q == '0 && target_q == '0 && timer_q == '0)
    else $error("state moved before the sequence started");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && cfg.phase_count != '0 |=> started_q && out_valid_o && running_o)
    else $error("tick with phases configured did not start the sequence");

  a_change_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changing_o |-> running_o)
    else $error("phase change reported before start");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(approach_signals_o))
    else $error("result changed while stalled");

endmodule

FILE: rtl/tlps_cfg_regs.sv
// Configuration register file of the phase sequencer.
module tlps_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlps_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tlps_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output tlps_pkg::cfg_t                   cfg_o
);
  import tlps_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_count    <= RST_PHASE_COUNT;
      cfg_q.yellow_time    <= RST_YELLOW;
      cfg_q.red_delay_time <= RST_RED_DELAY;
      cfg_q.phase_duration <= {NUM_DUR{RST_DURATION}};
      cfg_q.signal_table   <= RST_SIG_TABLE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PHASE_COUNT: cfg_q.phase_count       <= cfg_wdata_i[COUNT_W-1:0];
        REG_YELLOW:      cfg_q.yellow_time       <= cfg_wdata_i[MS_W-1:0];
        REG_RED_DELAY:   cfg_q.red_delay_time    <= cfg_wdata_i[MS_W-1:0];
        REG_DUR0:        cfg_q.phase_duration[0] <= cfg_wdata_i[MS_W-1:0];
        REG_DUR1:        cfg_q.phase_duration[1] <= cfg_wdata_i[MS_W-1:0];
        REG_DUR2:        cfg_q.phase_duration[2] <= cfg_wdata_i[MS_W-1:0];
        REG_DUR3:        cfg_q.phase_duration[3] <= cfg_wdata_i[MS_W-1:0];
        REG_SIG_TABLE:   cfg_q.signal_table      <= cfg_wdata_i[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/tlps_signal_map.sv
// Per-approach signal decode from shown and target phase during and between changes.
module tlps_signal_map #(
  parameter int NUM_APPROACHES = tlps_pkg::NUM_APPROACHES_DEF,
  parameter int PHASE_W        = 2
) (
  input  logic [tlps_pkg::TABLE_W-1:0] signal_table_i,
  input  logic [PHASE_W-1:0]           shown_phase_i,
  input  logic [PHASE_W-1:0]           target_phase_i,
  input  logic                         in_change_i,
  input  logic                         in_yellow_i,
  input  logic                         all_go_i,
  output logic [2*NUM_APPROACHES-1:0]  signals_o
);
  import tlps_pkg::*;

  logic [NUM_APPROACHES-1:0][1:0] prev_sig;
  logic [NUM_APPROACHES-1:0][1:0] next_sig;

  always_comb begin
    for (int a = 0; a < NUM_APPROACHES; a++) begin
      prev_sig[a] = table_signal(signal_table_i, int'(shown_phase_i), a, NUM_APPROACHES);
      next_sig[a] = table_signal(signal_table_i, int'(target_phase_i), a, NUM_APPROACHES);
      if (all_go_i) begin
        signals_o[2*a +: 2] = SIG_GO;
      end else if (!in_change_i || prev_sig[a] == next_sig[a]) begin
        signals_o[2*a +: 2] = prev_sig[a];
      end else if (next_sig[a] == SIG_STOP) begin
        signals_o[2*a +: 2] = in_yellow_i ? SIG_YELLOW : SIG_STOP;
      end else begin
        signals_o[2*a +: 2] = SIG_STOP;
      end
    end
  end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the traffic light phase sequencer: tick stimulus, signal prediction.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlps_pkg::*;

  localparam int LANES      = NUM_APPROACHES_DEF;
  localparam int ITEMS      = 400;
  localparam int REPORT_MAX = 40;
  localparam int LIMIT      = 200000;

  typedef struct packed {
    logic [2*LANES-1:0] signals;
    logic [1:0]         shown;
    logic [1:0]         target;
    logic               changing;
    logic               running;
  } light_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  cfg_reg_e               cfg_index = REG_PHASE_COUNT;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic [MS_W-1:0]        elapsed = '0;
  logic                   out_ready = 1'b0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [2*LANES-1:0]     approach_signals_o;
  logic [1:0]             shown_phase_o;
  logic [1:0]             target_phase_o;
  logic                   changing_o;
  logic                   running_o;

  traffic_light_phase_sequencer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .elapsed_i         (elapsed),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .approach_signals_o(approach_signals_o),
    .shown_phase_o     (shown_phase_o),
    .target_phase_o    (target_phase_o),
    .changing_o        (changing_o),
    .running_o         (running_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // configuration shadow
  logic [COUNT_W-1:0] cfg_count  = RST_PHASE_COUNT;
  logic [MS_W-1:0]    cfg_yellow = RST_YELLOW;
  logic [MS_W-1:0]    cfg_red    = RST_RED_DELAY;
  logic [MS_W-1:0]    cfg_dur [NUM_DUR] = '{RST_DURATION, RST_DURATION, RST_DURATION,
                                            RST_DURATION};
  logic [TABLE_W-1:0] cfg_table  = RST_SIG_TABLE;

  // predicted controller state
  logic               lamp_run = 1'b0;
  logic [1:0]         lamp_shown = '0;
  logic [1:0]         lamp_target = '0;
  logic               lamp_chg = 1'b0;
  logic [MS_W-1:0]    lamp_timer = '0;

  logic [MS_W-1:0]    tick_q [$];
  light_t             light_q [$];

  logic               idle_on = 1'b1;
  int unsigned        err_cnt = 0;
  int unsigned        ticks_sent = 0;
  int unsigned        results = 0;
  int unsigned        writes = 0;
  int unsigned        cycle_cnt = 0;

  function automatic logic [1:0] phase_code(logic [1:0] ph, int ap);
    logic [1:0] code;
    code = cfg_table[ph * 2 * LANES + ap * 2 +: 2];
    return (code == SIG_STOP3) ? SIG_STOP : code;
  endfunction

  // Advance the controller by one tick and queue the word it should produce.
  task automatic step_light(input logic [MS_W-1:0] ms);
    logic [COUNT_W-1:0] n;
    logic [MS_W:0]      acc;
    logic [2:0]         nxt;
    logic [1:0]         was, will, sig;
    light_t             exp_w;
    n = (cfg_count > 3'd4) ? 3'd4 : cfg_count;
    if (n != 0) begin
      if (!lamp_run) begin
        lamp_run    = 1'b1;
        lamp_shown  = '0;
        lamp_target = '0;
        lamp_chg    = 1'b1;
        lamp_timer  = '0;
      end
      acc = {1'b0, lamp_timer} + {1'b0, ms};
      lamp_timer = acc[MS_W] ? '1 : acc[MS_W-1:0];
      if (lamp_chg) begin
        // yellow + red can exceed the saturated timer: then the change never ends
        if ({1'b0, lamp_timer} >= {1'b0, cfg_yellow} + {1'b0, cfg_red}) begin
          lamp_shown = lamp_target;
          lamp_chg   = 1'b0;
        end
      end else if (lamp_timer >= cfg_dur[lamp_shown] && n > 1) begin
        nxt         = {1'b0, lamp_target} + 3'd1;
        lamp_target = 2'(nxt % n);
        lamp_chg    = 1'b1;
        lamp_timer  = '0;
      end
    end
    for (int a = 0; a < LANES; a++) begin
      if (!lamp_run || cfg_count == 0) begin
        sig = SIG_GO;
      end else begin
        was  = phase_code(lamp_shown, a);
        will = phase_code(lamp_target, a);
        if (!lamp_chg || was == will) begin
          sig = was;
        end else if (will == SIG_STOP) begin
          sig = (lamp_timer < cfg_yellow) ? SIG_YELLOW : SIG_STOP;
        end else begin
          sig = SIG_STOP;
        end
      end
      exp_w.signals[2*a +: 2] = sig;
    end
    exp_w.shown    = lamp_shown;
    exp_w.target   = lamp_target;
    exp_w.changing = lamp_chg;
    exp_w.running  = lamp_run;
    light_q = {light_q, exp_w};
  endtask

  // Driver: presents queued ticks, with a random gap after each accepted word while idle_on is set.
  int unsigned tick_gap = 0;
  logic        tick_load;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        step_light(elapsed);
        ticks_sent++;
        tick_gap  = idle_on ? $urandom_range(0, 15) : 0;
        tick_load = 1'b1;
      end else begin
        tick_load = !in_valid;
      end
      if (tick_load) begin
        if (tick_gap != 0) begin
          tick_gap--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          elapsed  <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void flag_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      if (err_cnt <= REPORT_MAX)
        $error("%s: expected %h, got %h", name, exp_v, act_v);
    end
  endfunction

  // Monitor: checks each result word against the oldest prediction, stalls at random while idle_on is set.
  int unsigned out_gap = 0;
  light_t      mon_want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        results++;
        if (light_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX) $error("result word with no tick pending");
        end else begin
          mon_want = light_q.pop_front();
          flag_field("approach_signals", mon_want.signals, approach_signals_o);
          flag_field("shown_phase", mon_want.shown, shown_phase_o);
          flag_field("target_phase", mon_want.target, target_phase_o);
          flag_field("changing", mon_want.changing, changing_o);
          flag_field("running", mon_want.running, running_o);
        end
        out_gap = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      REG_PHASE_COUNT: cfg_count = val[COUNT_W-1:0];
      REG_YELLOW:      cfg_yellow = val[MS_W-1:0];
      REG_RED_DELAY:   cfg_red = val[MS_W-1:0];
      REG_DUR0:        cfg_dur[0] = val[MS_W-1:0];
      REG_DUR1:        cfg_dur[1] = val[MS_W-1:0];
      REG_DUR2:        cfg_dur[2] = val[MS_W-1:0];
      REG_DUR3:        cfg_dur[3] = val[MS_W-1:0];
      REG_SIG_TABLE:   cfg_table = val[TABLE_W-1:0];
      default: ;
    endcase
    writes++;
  endtask

  // Block is idle once no tick is queued or presented and every word is back.
  // Checked at the falling edge so the driver's updates have landed.
  task automatic settle();
    while (tick_q.size() != 0 || in_valid || light_q.size() != 0 || out_valid_o)
      @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [MS_W-1:0] rand_ms(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return MS_W'($urandom);
    return MS_W'($urandom_range(0, span));
  endfunction

  function automatic logic [MS_W-1:0] rand_tick();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return MS_W'($urandom);
    return MS_W'($urandom_range(0, 1500));
  endfunction

  initial begin
    int unsigned      planned;
    int unsigned      burst;
    int unsigned      r;
    int unsigned      setups;
    logic [COUNT_W-1:0] cnt;
    bit               first;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no phases configured and not yet started: everything shows go
    tick_q = {16'h0000, 16'hFFFF};
    settle();

    // full cycle through four phases, including a zero-length and a maximal one
    idle_on = 1'b0;
    cfg_write(REG_PHASE_COUNT, 64'd4);
    cfg_write(REG_YELLOW, 64'd2000);
    cfg_write(REG_RED_DELAY, 64'd1000);
    cfg_write(REG_DUR0, 64'd6000);
    cfg_write(REG_DUR1, 64'd4000);
    cfg_write(REG_DUR2, 64'd0);
    cfg_write(REG_DUR3, 64'd65535);
    cfg_write(REG_SIG_TABLE, 64'h0F5A_A5F0_1B1B_E4E4);
    cfg_we <= 1'b0;
    tick_q = {16'd0, 16'd1999, 16'd1, 16'd999, 16'd1, 16'd3000, 16'd2500, 16'd1500,
              16'd1, 16'd3000, 16'd0, 16'hFFFF, 16'hFFFF};
    settle();

    // single phase never moves on
    idle_on = 1'b1;
    cfg_write(REG_PHASE_COUNT, 64'd1);
    cfg_write(REG_YELLOW, 64'd0);
    cfg_write(REG_RED_DELAY, 64'd0);
    cfg_we <= 1'b0;
    tick_q = {16'd100, 16'hFFFF};
    settle();

    // count above the maximum, and a change too long to ever finish
    cfg_write(REG_PHASE_COUNT, 64'd7);
    cfg_write(REG_YELLOW, 64'hFFFF);
    cfg_write(REG_RED_DELAY, 64'hFFFF);
    cfg_we <= 1'b0;
    tick_q = {16'hFFFF, 16'hFFFF, 16'd0};
    settle();

    // phases switched off while running: state holds, all go
    cfg_write(REG_PHASE_COUNT, 64'd0);
    cfg_we <= 1'b0;
    tick_q = {16'd7, 16'h5A5A};
    planned = 22;
    setups  = 5;
    first   = 1'b1;

    while (planned < ITEMS) begin
      settle();
      idle_on = ($urandom_range(0, 3) != 0);
      if (first || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 15);
        if (r == 0)      cnt = 3'd0;
        else if (r < 3)  cnt = 3'd1;
        else if (r < 5)  cnt = COUNT_W'($urandom_range(5, 7));
        else             cnt = COUNT_W'($urandom_range(2, 4));
        cfg_write(REG_PHASE_COUNT, 64'(cnt));
      end
      if (first || $urandom_range(0, 1)) cfg_write(REG_YELLOW, 64'(rand_ms(3000)));
      if (first || $urandom_range(0, 1)) cfg_write(REG_RED_DELAY, 64'(rand_ms(3000)));
      if (first || $urandom_range(0, 1)) cfg_write(REG_DUR0, 64'(rand_ms(8000)));
      if (first || $urandom_range(0, 1)) cfg_write(REG_DUR1, 64'(rand_ms(8000)));
      if (first || $urandom_range(0, 1)) cfg_write(REG_DUR2, 64'(rand_ms(8000)));
      if (first || $urandom_range(0, 1)) cfg_write(REG_DUR3, 64'(rand_ms(8000)));
      if (first || $urandom_range(0, 1)) cfg_write(REG_SIG_TABLE, {$urandom, $urandom});
      cfg_we <= 1'b0;
      first = 1'b0;
      burst = $urandom_range(20, 60);
      repeat (burst) tick_q = {tick_q, rand_tick()};
      planned += burst;
      setups++;
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d ticks sent, %0d result words checked", ticks_sent, results);
    $display("summary: %0d register writes across %0d settings", writes, setups);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
